[hdl/atte_pkg.sv]
// ----------------------------------------------------------------------------
// atte_pkg
// Shared types, codes and constants for the ANSI text terminal engine.
// ----------------------------------------------------------------------------
package atte_pkg;

  localparam int MAX_COLS_DEF   = 512;
  localparam int MAX_ROWS_DEF   = 256;
  localparam int NUM_PARAMS_DEF = 4;
  localparam int MAX_SEQ_DEF    = 32;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [13:0] PARAM_LIMIT = 14'd999;
  localparam logic [13:0] PRIV_CURSOR = 14'd25;

  typedef enum logic [1:0] {
    MODE_TERM  = 2'd0,
    MODE_RAW   = 2'd1,
    MODE_COLOR = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    OP_DRAW   = 2'd0,
    OP_FILL   = 2'd1,
    OP_SCROLL = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PH_GROUND = 2'd0,
    PH_ESC    = 2'd1,
    PH_CSI    = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    REG_COLUMNS    = 2'd0,
    REG_TEXT_ROWS  = 2'd1,
    REG_DEFAULT_FG = 2'd2,
    REG_DEFAULT_BG = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] bg;
    logic [31:0] fg;
    logic [7:0]  character;
    logic [9:0]  col_end;
    logic [8:0]  col;
    logic [7:0]  row;
    op_t         op;
  } cmd_t;

  function automatic logic [31:0] palette(input logic [2:0] idx);
    case (idx)
      3'd0:    palette = 32'h151515;
      3'd1:    palette = 32'hf7768e;
      3'd2:    palette = 32'h9ece6a;
      3'd3:    palette = 32'he0af68;
      3'd4:    palette = 32'h7aa2f7;
      3'd5:    palette = 32'hbb9af7;
      3'd6:    palette = 32'h7dcfff;
      3'd7:    palette = 32'hc0caf5;
      default: palette = 32'h0;
    endcase
  endfunction

endpackage

[hdl/ansi_text_terminal_engine.sv]
// ----------------------------------------------------------------------------
// ansi_text_terminal_engine
// Console byte stream to screen draw / fill / scroll / clear commands.
// ----------------------------------------------------------------------------
// Each item is worked straight from the input bus into a two-entry result
// buffer, and its first result is offered the cycle after the item is taken.
// An item giving one result or none is taken every cycle while the output is
// ready. An item giving two results (scroll then draw, etc.) holds the input
// while the second result drains. Throughput is therefore set by the single
// output port. Result tdata packs, from bit 0: op, row, col, col_end,
// character, fg, bg, scroll_count, cursor_column, cursor_line, cursor_shown
// (124 bits, zero pad to 128). tlast marks the item's final result.
module ansi_text_terminal_engine #(
  parameter int MAX_COLS   = atte_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS   = atte_pkg::MAX_ROWS_DEF,
  parameter int NUM_PARAMS = atte_pkg::NUM_PARAMS_DEF,
  parameter int MAX_SEQ    = atte_pkg::MAX_SEQ_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // mode[1:0], byte_req[9:2], fg_in[41:10], bg_in[73:42], zero pad to 80
  input  logic [79:0]  in_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  output logic         out_tvalid,
  input  logic         out_tready,
  // op, row, col, col_end, character, fg, bg, scroll_count,
  // cursor_column, cursor_line, cursor_shown from bit 0, zero pad to 128
  output logic [127:0] out_tdata,
  output logic         out_tlast
);

  localparam int PIW = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;

  // configuration
  logic [9:0]  columns_r;
  logic [8:0]  text_rows_r;
  logic [31:0] default_fg_r, default_bg_r;

  // state
  logic [9:0]  cur_col_r, cur_col_nxt;
  logic [7:0]  cur_row_r, cur_row_nxt;
  logic [31:0] fg_now_r, fg_now_nxt, bg_now_r, bg_now_nxt;
  atte_pkg::phase_t phase_r, phase_nxt;
  logic [5:0]  seq_len_r, seq_len_nxt;
  logic [PIW-1:0] pidx_r, pidx_nxt;
  logic [13:0] pval_r [NUM_PARAMS];
  logic [13:0] pval_nxt [NUM_PARAMS];
  logic        priv_r, priv_nxt;
  logic        cur_on_r, cur_on_nxt;

  // output buffer: up to two results
  atte_pkg::cmd_t buf_r [2];
  logic [1:0]  cnt_r;
  logic        rd_r;
  logic [9:0]  o_col_r;
  logic [7:0]  o_row_r;
  logic        o_on_r;
  logic [3:0]  o_scnt_r [2];

  logic [1:0]  mode;
  logic [7:0]  byte_in;
  assign mode    = in_tdata[1:0];
  assign byte_in = in_tdata[9:2];

  assign cfg_ready = 1'b1;
  // buffer empty, or last result leaving this cycle
  assign in_tready = (cnt_r == 2'd0) ||
                     (out_tready && (cnt_r == 2'd1 || rd_r));

  // effective geometry
  logic [10:0] cols_e;
  logic [9:0]  rows_e;
  always_comb begin
    cols_e = (columns_r == 10'd0) ? 11'd1 : {1'b0, columns_r};
    if (cols_e > 11'(MAX_COLS)) cols_e = 11'(MAX_COLS);
    rows_e = (text_rows_r == 9'd0) ? 10'd1 : {1'b0, text_rows_r};
    if (rows_e > 10'(MAX_ROWS)) rows_e = 10'(MAX_ROWS);
  end

  logic [3:0] scnt;
  always_comb begin
    scnt = (rows_e[9:2] > 8'd8) ? 4'd8 : rows_e[5:2];
    if (rows_e[9:2] == 8'd0) scnt = 4'd1;
  end

  // result slots
  atte_pkg::cmd_t e_cmd [2];
  logic [3:0]  e_sc [2];
  logic [1:0]  e_n;
  logic        do_put;
  logic [7:0]  put_ch;
  logic        run;

  logic [10:0] c_w, nxt_tab, t_end;
  logic [9:0]  r_w;
  logic [13:0] p0, n, n1;
  logic [14:0] acc;

  always_comb begin
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    fg_now_nxt  = fg_now_r;
    bg_now_nxt  = bg_now_r;
    phase_nxt   = phase_r;
    seq_len_nxt = seq_len_r;
    pidx_nxt    = pidx_r;
    for (int i = 0; i < NUM_PARAMS; i++) pval_nxt[i] = pval_r[i];
    priv_nxt    = priv_r;
    cur_on_nxt  = cur_on_r;
    e_n    = 2'd0;
    e_cmd[0] = '0;
    e_cmd[1] = '0;
    e_sc[0] = 4'd0;
    e_sc[1] = 4'd0;
    do_put = 1'b0;
    put_ch = byte_in;
    run    = 1'b0;
    c_w = {1'b0, cur_col_r};
    r_w = {2'b0, cur_row_r};
    nxt_tab = '0;
    t_end = '0;
    acc = '0;
    p0 = pval_r[0];
    n  = (p0 == 14'd0) ? 14'd1 : p0;
    n1 = (pval_r[1] == 14'd0) ? 14'd1 : pval_r[1];

    case (mode)
      atte_pkg::MODE_TERM: begin
        if (byte_in == atte_pkg::CH_ESC) begin
          phase_nxt = atte_pkg::PH_ESC;
          seq_len_nxt = 6'd0;
        end else if (phase_r == atte_pkg::PH_ESC) begin
          phase_nxt = (byte_in == 8'h5b) ? atte_pkg::PH_CSI : atte_pkg::PH_GROUND;
          pidx_nxt = '0;
          priv_nxt = 1'b0;
          for (int i = 0; i < NUM_PARAMS; i++) pval_nxt[i] = '0;
        end else if (phase_r == atte_pkg::PH_CSI) begin
          phase_nxt = atte_pkg::PH_GROUND;
          if (seq_len_r != 6'd63) seq_len_nxt = seq_len_r + 6'd1;
          if ({1'b0, seq_len_nxt} > 7'(MAX_SEQ)) begin
            // overlong sequence dropped
          end else if (byte_in == 8'h3f && seq_len_nxt == 6'd1) begin
            priv_nxt = 1'b1;
            phase_nxt = atte_pkg::PH_CSI;
          end else if (byte_in >= 8'h30 && byte_in <= 8'h39) begin
            if (pval_r[pidx_r] <= atte_pkg::PARAM_LIMIT) begin
              acc = {pval_r[pidx_r], 1'b0} + {pval_r[pidx_r][11:0], 3'b0}
                    + 15'(byte_in[3:0]);
              pval_nxt[pidx_r] = acc[13:0];
              phase_nxt = atte_pkg::PH_CSI;
            end
          end else if (byte_in == 8'h3b && 32'(pidx_r) + 1 < NUM_PARAMS) begin
            pidx_nxt = pidx_r + 1'b1;
            phase_nxt = atte_pkg::PH_CSI;
          end else if (byte_in >= 8'h40 && byte_in <= 8'h7e) begin
            run = 1'b1;
          end
        end else begin
          phase_nxt = atte_pkg::PH_GROUND;
          if (byte_in == atte_pkg::CH_BS || byte_in == atte_pkg::CH_LF ||
              byte_in == atte_pkg::CH_CR || byte_in == atte_pkg::CH_TAB ||
              (byte_in >= 8'h20 && byte_in < 8'h7f))
            do_put = 1'b1;
        end
      end
      atte_pkg::MODE_RAW: begin
        phase_nxt = atte_pkg::PH_GROUND;
        cur_on_nxt = 1'b0;
        do_put = 1'b1;
      end
      atte_pkg::MODE_COLOR: begin
        fg_now_nxt = in_tdata[41:10];
        bg_now_nxt = in_tdata[73:42];
      end
      default: begin
        cur_col_nxt = '0;
        cur_row_nxt = '0;
        e_cmd[0].op = atte_pkg::OP_CLEAR;
        e_cmd[0].character = atte_pkg::CH_SPACE;
        e_n = 2'd1;
      end
    endcase

    if (run) begin
      if (priv_r) begin
        if (p0 == atte_pkg::PRIV_CURSOR && (byte_in == 8'h68 || byte_in == 8'h6c))
          cur_on_nxt = (byte_in == 8'h68);
      end else begin
        case (byte_in)
          8'h41: cur_row_nxt = ({2'b0, n} > 16'(cur_row_r)) ? 8'd0
                               : cur_row_r - n[7:0];
          8'h42: cur_row_nxt = (15'(cur_row_r) + 15'(n) < 15'(rows_e))
                               ? 8'(cur_row_r + n[7:0]) : 8'(rows_e - 10'd1);
          8'h43: cur_col_nxt = (15'(cur_col_r) + 15'(n) < 15'(cols_e))
                               ? 10'(cur_col_r + n[9:0]) : 10'(cols_e - 11'd1);
          8'h44: cur_col_nxt = (n > 14'(cur_col_r)) ? 10'd0 : cur_col_r - n[9:0];
          8'h47: cur_col_nxt = (n <= 14'(cols_e)) ? 10'(n - 14'd1)
                               : 10'(cols_e - 11'd1);
          8'h48, 8'h66: begin
            cur_row_nxt = (n <= 14'(rows_e)) ? 8'(n - 14'd1) : 8'(rows_e - 10'd1);
            cur_col_nxt = (n1 <= 14'(cols_e)) ? 10'(n1 - 14'd1)
                          : 10'(cols_e - 11'd1);
          end
          8'h4b: begin
            if ((p0 == 14'd0 || p0 == 14'd2) && r_w < rows_e &&
                (p0 == 14'd2 || c_w < cols_e)) begin
              e_cmd[0].op = atte_pkg::OP_FILL;
              e_cmd[0].row = cur_row_r;
              e_cmd[0].col = (p0 == 14'd2) ? 9'd0 : cur_col_r[8:0];
              e_cmd[0].col_end = cols_e[9:0];
              e_cmd[0].character = atte_pkg::CH_SPACE;
              e_n = 2'd1;
            end
          end
          8'h4a: begin
            if (p0 == 14'd2) begin
              e_cmd[0].op = atte_pkg::OP_CLEAR;
              e_cmd[0].character = atte_pkg::CH_SPACE;
              e_n = 2'd1;
            end
          end
          8'h6d: begin
            for (int i = 0; i < NUM_PARAMS; i++) begin
              if (32'(i) <= 32'(pidx_r)) begin
                if (pval_r[i] == 14'd0 || pval_r[i] == 14'd39) fg_now_nxt = default_fg_r;
                if (pval_r[i] == 14'd0 || pval_r[i] == 14'd49) bg_now_nxt = default_bg_r;
                if (pval_r[i] >= 14'd30 && pval_r[i] <= 14'd37)
                  fg_now_nxt = atte_pkg::palette(3'(pval_r[i] - 14'd30));
                if (pval_r[i] >= 14'd40 && pval_r[i] <= 14'd47)
                  bg_now_nxt = atte_pkg::palette(3'(pval_r[i] - 14'd40));
              end
            end
          end
          default: ;
        endcase
      end
    end

    if (do_put) begin
      if (put_ch == atte_pkg::CH_CR) begin
        c_w = '0;
      end else if (put_ch == atte_pkg::CH_LF) begin
        c_w = '0;
        if (r_w + 10'd1 >= rows_e) begin
          e_cmd[0].op = atte_pkg::OP_SCROLL;
          e_cmd[0].character = atte_pkg::CH_SPACE;
          e_sc[0] = scnt;
          e_n = 2'd1;
          r_w = rows_e - 10'(scnt);
        end else r_w = r_w + 10'd1;
      end else if (put_ch == atte_pkg::CH_BS) begin
        if (c_w == 11'd0 && r_w != 10'd0) begin
          r_w = r_w - 10'd1;
          c_w = cols_e;
        end
        if (c_w != 11'd0) begin
          c_w = c_w - 11'd1;
          if (c_w < cols_e && r_w < rows_e) begin
            e_cmd[0].op = atte_pkg::OP_DRAW;
            e_cmd[0].row = r_w[7:0];
            e_cmd[0].col = c_w[8:0];
            e_cmd[0].character = atte_pkg::CH_SPACE;
            e_n = 2'd1;
          end
        end
      end else begin
        // tab fill or deferred wrap may come first
        if (put_ch == atte_pkg::CH_TAB) begin
          nxt_tab = (c_w + 11'd8) & ~11'd7;
          if (c_w < cols_e) begin
            t_end = (nxt_tab < cols_e) ? nxt_tab : cols_e;
            if (r_w < rows_e) begin
              e_cmd[0].op = atte_pkg::OP_FILL;
              e_cmd[0].row = r_w[7:0];
              e_cmd[0].col = c_w[8:0];
              e_cmd[0].col_end = t_end[9:0];
              e_cmd[0].character = atte_pkg::CH_SPACE;
              e_n = 2'd1;
            end
            c_w = t_end;
          end
        end
        if (c_w >= cols_e) begin
          c_w = '0;
          if (r_w + 10'd1 >= rows_e) begin
            e_cmd[e_n[0]].op = atte_pkg::OP_SCROLL;
            e_cmd[e_n[0]].character = atte_pkg::CH_SPACE;
            e_sc[e_n[0]] = scnt;
            e_n = e_n + 2'd1;
            r_w = rows_e - 10'(scnt);
          end else r_w = r_w + 10'd1;
        end
        if (put_ch != atte_pkg::CH_TAB) begin
          if (c_w < cols_e && r_w < rows_e) begin
            e_cmd[e_n[0]].op = atte_pkg::OP_DRAW;
            e_cmd[e_n[0]].row = r_w[7:0];
            e_cmd[e_n[0]].col = c_w[8:0];
            e_cmd[e_n[0]].character = put_ch;
            e_n = e_n + 2'd1;
          end
          c_w = c_w + 11'd1;
        end
      end
      cur_col_nxt = c_w[9:0];
      cur_row_nxt = r_w[7:0];
    end

    // commands carry the colours in force before this item
    for (int k = 0; k < 2; k++) begin
      e_cmd[k].fg = fg_now_r;
      e_cmd[k].bg = bg_now_r;
    end
  end

  logic in_acc, out_acc;
  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r    <= 10'd128;
      text_rows_r  <= 9'd48;
      default_fg_r <= 32'h00ffffff;
      default_bg_r <= 32'h0;
      cur_col_r <= '0;
      cur_row_r <= '0;
      fg_now_r  <= 32'h00ffffff;
      bg_now_r  <= 32'h0;
      phase_r   <= atte_pkg::PH_GROUND;
      seq_len_r <= '0;
      pidx_r    <= '0;
      for (int i = 0; i < NUM_PARAMS; i++) pval_r[i] <= '0;
      priv_r    <= 1'b0;
      cur_on_r  <= 1'b0;
      cnt_r     <= '0;
      rd_r      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          atte_pkg::REG_COLUMNS:    columns_r    <= cfg_data[9:0];
          atte_pkg::REG_TEXT_ROWS:  text_rows_r  <= cfg_data[8:0];
          atte_pkg::REG_DEFAULT_FG: default_fg_r <= cfg_data;
          atte_pkg::REG_DEFAULT_BG: default_bg_r <= cfg_data;
          default: ;
        endcase
      end
      if (in_acc) begin
        cur_col_r <= cur_col_nxt;
        cur_row_r <= cur_row_nxt;
        fg_now_r  <= fg_now_nxt;
        bg_now_r  <= bg_now_nxt;
        phase_r   <= phase_nxt;
        seq_len_r <= seq_len_nxt;
        pidx_r    <= pidx_nxt;
        for (int i = 0; i < NUM_PARAMS; i++) pval_r[i] <= pval_nxt[i];
        priv_r    <= priv_nxt;
        cur_on_r  <= cur_on_nxt;
        cnt_r     <= e_n;
        rd_r      <= 1'b0;
      end else if (out_acc) begin
        if (cnt_r == 2'd2 && !rd_r) rd_r <= 1'b1;
        else begin
          cnt_r <= '0;
          rd_r  <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      buf_r[0]    <= e_cmd[0];
      buf_r[1]    <= e_cmd[1];
      o_scnt_r[0] <= e_sc[0];
      o_scnt_r[1] <= e_sc[1];
      o_col_r     <= cur_col_nxt;
      o_row_r     <= cur_row_nxt;
      o_on_r      <= cur_on_nxt;
    end
  end

  atte_pkg::cmd_t sel;
  logic [3:0] sel_sc;
  assign sel    = buf_r[rd_r];
  assign sel_sc = o_scnt_r[rd_r];

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tlast  = (cnt_r == 2'd1) || rd_r;
  assign out_tdata  = {4'b0, o_on_r, o_row_r, o_col_r, sel_sc, sel.bg, sel.fg,
                       sel.character, sel.col_end, sel.col, sel.row, sel.op};

endmodule

[hdl/atte_checker.sv]
// ----------------------------------------------------------------------------
// atte_checker
// Port-level checks on the terminal engine, bound to the top level.
// ----------------------------------------------------------------------------
module atte_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [127:0] out_tdata,
  input logic         out_tlast
);

  // a non-final result is always followed by the item's final one
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid && out_tlast)
    else $error("second result missing");

  // no new item while a non-final result is pending
  a_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("item accepted mid pair");

  // scroll count only on scroll ops
  a_scnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != 2'd2 |-> out_tdata[104:101] == 4'd0)
    else $error("scroll count on non-scroll op");

  // stalled output holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && out_tvalid)
    else $error("output changed under stall");

endmodule

bind ansi_text_terminal_engine atte_checker u_atte_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tlast(out_tlast)
);

[tb/ansi_text_terminal_engine_tb.sv]
// ----------------------------------------------------------------------------
// ansi_text_terminal_engine_tb
// Drives console bytes, raw bytes, colour and clear requests through the
// terminal engine under several screen sizes and checks every screen command
// against a behavioural copy of the cursor, colour and CSI parser logic.
// ----------------------------------------------------------------------------
module ansi_text_terminal_engine_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 12;

  typedef struct {
    atte_pkg::mode_t mode;
    logic [7:0]  b;
    logic [31:0] fg;
    logic [31:0] bg;
  } item_t;

  typedef struct {
    atte_pkg::op_t op;
    logic [7:0]  row;
    logic [8:0]  col;
    logic [9:0]  col_end;
    logic [7:0]  ch;
    logic [31:0] fg;
    logic [31:0] bg;
    logic [3:0]  scnt;
    logic [9:0]  ccol;
    logic [7:0]  crow;
    logic        shown;
    logic        last;
  } cmd_res_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  logic [79:0]   in_tdata = '0;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [1:0]    cfg_index = '0;
  logic [31:0]   cfg_data = '0;
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [127:0]  out_tdata;
  logic          out_tlast;

  ansi_text_terminal_engine u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // terminal state as the engine should hold it
  int          scr_cols = 128, scr_rows = 48;
  logic [31:0] dflt_fg = 32'h00ff_ffff, dflt_bg = '0;
  int          cur_c = 0, cur_r = 0;
  logic [31:0] fg_now = 32'h00ff_ffff, bg_now = '0;
  atte_pkg::phase_t ph = atte_pkg::PH_GROUND;
  int          seq_len = 0, pidx = 0;
  int          pval[4] = '{0, 0, 0, 0};
  bit          priv = 0, curs_on = 0;
  cmd_res_t    cmds[2];
  int          ncmd;

  item_t       item_q[$];
  cmd_res_t    cmd_q[$];
  int          errors = 0;
  int          n_pushed = 0;
  bit          no_idle = 0;
  bit          hold_go = 0;
  bit          hold_out = 0;

  function automatic int eff_cols();
    return scr_cols == 0 ? 1 : (scr_cols > atte_pkg::MAX_COLS_DEF ?
                                atte_pkg::MAX_COLS_DEF : scr_cols);
  endfunction

  function automatic int eff_rows();
    return scr_rows == 0 ? 1 : (scr_rows > atte_pkg::MAX_ROWS_DEF ?
                                atte_pkg::MAX_ROWS_DEF : scr_rows);
  endfunction

  function automatic void emit_cmd(atte_pkg::op_t op, int row, int col, int cend, int ch,
                                   int sc);
    if (ncmd < 2) begin
      cmds[ncmd].op = op;
      cmds[ncmd].row = row[7:0];
      cmds[ncmd].col = col[8:0];
      cmds[ncmd].col_end = cend[9:0];
      cmds[ncmd].ch = ch[7:0];
      cmds[ncmd].fg = fg_now;
      cmds[ncmd].bg = bg_now;
      cmds[ncmd].scnt = sc[3:0];
      ncmd++;
    end
  endfunction

  function automatic void draw_cell(int col, int row, int ch);
    if (col < eff_cols() && row < eff_rows())
      emit_cmd(atte_pkg::OP_DRAW, row, col, 0, ch, 0);
  endfunction

  function automatic void next_line();
    int rows, cnt;
    rows = eff_rows();
    cur_c = 0;
    if (cur_r + 1 >= rows) begin
      cnt = rows / 4;
      if (cnt == 0) cnt = 1;
      if (cnt > 8) cnt = 8;
      emit_cmd(atte_pkg::OP_SCROLL, 0, 0, 0, atte_pkg::CH_SPACE, cnt);
      cur_r = rows - cnt;
    end else begin
      cur_r = cur_r + 1;
    end
  endfunction

  function automatic void put_char(logic [7:0] ch);
    int cols, nxt, stop;
    cols = eff_cols();
    if (ch == atte_pkg::CH_CR) begin
      cur_c = 0;
    end else if (ch == atte_pkg::CH_LF) begin
      next_line();
    end else if (ch == atte_pkg::CH_BS) begin
      if (cur_c == 0 && cur_r > 0) begin
        cur_r--;
        cur_c = cols;
      end
      if (cur_c > 0) begin
        cur_c--;
        draw_cell(cur_c, cur_r, atte_pkg::CH_SPACE);
      end
    end else if (ch == atte_pkg::CH_TAB) begin
      nxt = (cur_c + 8) & ~7;
      if (cur_c < cols) begin
        stop = nxt < cols ? nxt : cols;
        if (cur_r < eff_rows())
          emit_cmd(atte_pkg::OP_FILL, cur_r, cur_c, stop, atte_pkg::CH_SPACE, 0);
        cur_c = stop;
      end
      if (cur_c >= cols) next_line();
    end else begin
      if (cur_c >= cols) next_line();
      draw_cell(cur_c, cur_r, ch);
      cur_c++;
    end
  endfunction

  function automatic logic [31:0] sgr_colour(int k);
    case (k)
      0: return 32'h151515;
      1: return 32'hf7768e;
      2: return 32'h9ece6a;
      3: return 32'he0af68;
      4: return 32'h7aa2f7;
      5: return 32'hbb9af7;
      6: return 32'h7dcfff;
      default: return 32'hc0caf5;
    endcase
  endfunction

  function automatic void run_seq(logic [7:0] fin);
    int cols, rows, p0, n, p, start;
    cols = eff_cols();
    rows = eff_rows();
    p0 = pval[0];
    n = p0 != 0 ? p0 : 1;
    if (priv) begin
      if (p0 == atte_pkg::PRIV_CURSOR && (fin == "h" || fin == "l")) curs_on = (fin == "h");
      return;
    end
    case (fin)
      "A": cur_r = n > cur_r ? 0 : cur_r - n;
      "B": cur_r = cur_r + n < rows ? cur_r + n : rows - 1;
      "C": cur_c = cur_c + n < cols ? cur_c + n : cols - 1;
      "D": cur_c = n > cur_c ? 0 : cur_c - n;
      "G": cur_c = n <= cols ? n - 1 : cols - 1;
      "H", "f": begin
        cur_r = n <= rows ? n - 1 : rows - 1;
        n = pval[1] != 0 ? pval[1] : 1;
        cur_c = n <= cols ? n - 1 : cols - 1;
      end
      "K": begin
        if ((p0 == 0 || p0 == 2) && cur_r < rows) begin
          start = p0 == 2 ? 0 : cur_c;
          if (start < cols)
            emit_cmd(atte_pkg::OP_FILL, cur_r, start, cols, atte_pkg::CH_SPACE, 0);
        end
      end
      "J": if (p0 == 2) emit_cmd(atte_pkg::OP_CLEAR, 0, 0, 0, atte_pkg::CH_SPACE, 0);
      "m": begin
        for (int i = 0; i <= pidx && i < 4; i++) begin
          p = pval[i];
          if (p == 0 || p == 39) fg_now = dflt_fg;
          if (p == 0 || p == 49) bg_now = dflt_bg;
          if (p >= 30 && p <= 37) fg_now = sgr_colour(p - 30);
          if (p >= 40 && p <= 47) bg_now = sgr_colour(p - 40);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void term_byte(logic [7:0] c);
    int k;
    if (c == atte_pkg::CH_ESC) begin
      ph = atte_pkg::PH_ESC;
      seq_len = 0;
    end else if (ph == atte_pkg::PH_ESC) begin
      ph = c == "[" ? atte_pkg::PH_CSI : atte_pkg::PH_GROUND;
      pidx = 0;
      priv = 0;
      for (int i = 0; i < 4; i++) pval[i] = 0;
    end else if (ph == atte_pkg::PH_CSI) begin
      if (seq_len < 63) seq_len++;
      if (seq_len > atte_pkg::MAX_SEQ_DEF) begin
        ph = atte_pkg::PH_GROUND;
      end else if (c == "?" && seq_len == 1) begin
        priv = 1;
      end else if (c >= "0" && c <= "9") begin
        k = pidx < 4 ? pidx : 0;
        if (pval[k] > atte_pkg::PARAM_LIMIT) ph = atte_pkg::PH_GROUND;
        else pval[k] = pval[k] * 10 + (c - "0");
      end else if (c == ";" && pidx + 1 < 4) begin
        pidx++;
      end else begin
        if (c >= 8'h40 && c <= 8'h7e) run_seq(c);
        ph = atte_pkg::PH_GROUND;
      end
    end else begin
      if (c == atte_pkg::CH_BS || c == atte_pkg::CH_LF || c == atte_pkg::CH_CR ||
          c == atte_pkg::CH_TAB || (c >= 32 && c < 127))
        put_char(c);
    end
  endfunction

  // works out the commands one accepted item gives and queues them
  function automatic void predict_cmds(item_t it);
    ncmd = 0;
    case (it.mode)
      atte_pkg::MODE_TERM: term_byte(it.b);
      atte_pkg::MODE_RAW: begin
        ph = atte_pkg::PH_GROUND;
        curs_on = 0;
        put_char(it.b);
      end
      atte_pkg::MODE_COLOR: begin
        fg_now = it.fg;
        bg_now = it.bg;
      end
      default: begin
        cur_c = 0;
        cur_r = 0;
        emit_cmd(atte_pkg::OP_CLEAR, 0, 0, 0, atte_pkg::CH_SPACE, 0);
      end
    endcase
    cur_c &= 32'h3ff;
    cur_r &= 32'hff;
    for (int k = 0; k < ncmd; k++) begin
      cmds[k].ccol = cur_c[9:0];
      cmds[k].crow = cur_r[7:0];
      cmds[k].shown = curs_on;
      cmds[k].last = (k == ncmd - 1);
      cmd_q.push_back(cmds[k]);
    end
  endfunction

  function automatic logic [124:0] pack_cmd(cmd_res_t r);
    return {r.last, r.shown, r.crow, r.ccol, r.scnt, r.bg, r.fg, r.ch, r.col_end,
            r.col, r.row, r.op};
  endfunction

  // ---------------- input driver ----------------
  item_t in_item;
  bit    in_taken = 0;
  int    in_gap = 0;

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      predict_cmds(in_item);
      in_taken = 1;
    end
  end

  always @(negedge clk) begin
    if (!in_tvalid || in_taken) begin
      in_taken = 0;
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (item_q.size() > 0) begin
        in_item = item_q.pop_front();
        in_tdata <= {6'b0, in_item.bg, in_item.fg, in_item.b, in_item.mode};
        in_tvalid <= 1'b1;
        in_gap = no_idle ? 0 : $urandom_range(0, 4);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------- result monitor ----------------
  bit out_taken = 0;
  int out_stall = 0;

  always @(posedge clk) begin
    cmd_res_t e;
    logic [124:0] got;
    if (rst_n && out_tvalid && out_tready) begin
      out_taken = 1;
      got = {out_tlast, out_tdata[123:0]};
      if (cmd_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected command, expected none, actual %h", $realtime, got);
      end else begin
        e = cmd_q.pop_front();
        if (got !== pack_cmd(e)) begin
          errors++;
          $display("%0t: command mismatch, expected %h, actual %h", $realtime,
                   pack_cmd(e), got);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_out) begin
      out_tready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (out_taken) out_stall = no_idle ? 0 : $urandom_range(0, 4);
    end
    out_taken = 0;
  end

  // long receiver hold-off while the sender keeps offering items
  initial begin
    wait (hold_go);
    hold_out = 1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_out = 0;
  end

  // ---------------- watchdog ----------------
  int quiet = 0;

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  task automatic push_item(atte_pkg::mode_t m, logic [7:0] b, logic [31:0] f,
                           logic [31:0] g);
    item_t it;
    it.mode = m;
    it.b = b;
    it.fg = f;
    it.bg = g;
    item_q.push_back(it);
    n_pushed++;
  endtask

  task automatic push_term(logic [7:0] b);
    push_item(atte_pkg::MODE_TERM, b, $urandom, $urandom);
  endtask

  task automatic push_number(int v);
    string s;
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) push_term(s[i]);
  endtask

  task automatic push_seq(bit is_priv, int np, int p0, int p1, logic [7:0] fin);
    push_term(atte_pkg::CH_ESC);
    push_term("[");
    if (is_priv) push_term("?");
    for (int i = 0; i < np; i++) begin
      if (i > 0) push_term(";");
      push_number(i == 0 ? p0 : (i == 1 ? p1 : $urandom_range(0, 49)));
    end
    push_term(fin);
  endtask

  function automatic int rand_param();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return $urandom_range(1, 3);
      2: return $urandom_range(30, 49);
      3: return $urandom_range(0, 999);
      4: return $urandom_range(1000, 9999);
      5: return $urandom_range(1, 300);
      6: return 2;
      default: return $urandom_range(0, 20);
    endcase
  endfunction

  function automatic logic [7:0] rand_final();
    string finals;
    finals = "ABCDGHfKJmhl";
    case ($urandom_range(0, 9))
      0: return 8'($urandom_range(8'h40, 8'h7e));
      1: return 8'($urandom_range(0, 255));
      default: return finals[$urandom_range(0, finals.len() - 1)];
    endcase
  endfunction

  task automatic push_random_chunk();
    int n;
    case ($urandom_range(0, 15))
      0, 1, 2: begin
        n = $urandom_range(1, 12);
        repeat (n) push_term(8'($urandom_range(8'h20, 8'h7e)));
      end
      3, 4: begin
        case ($urandom_range(0, 3))
          0: push_term(atte_pkg::CH_BS);
          1: push_term(atte_pkg::CH_TAB);
          2: push_term(atte_pkg::CH_LF);
          default: push_term(atte_pkg::CH_CR);
        endcase
      end
      5, 6, 7, 8: push_seq($urandom_range(0, 7) == 0, $urandom_range(0, 5),
                           rand_param(), rand_param(), rand_final());
      9: push_seq(1, 1, atte_pkg::PRIV_CURSOR, 0, $urandom_range(0, 1) ? "h" : "l");
      10: push_term(8'($urandom_range(0, 255)));
      11: push_item(atte_pkg::MODE_RAW, 8'($urandom_range(0, 255)), $urandom, $urandom);
      12: push_item(atte_pkg::MODE_COLOR, 8'($urandom), $urandom, $urandom);
      13: begin
        // parameter run near the sequence length cap, mostly long enough to exceed it
        push_term(atte_pkg::CH_ESC);
        push_term("[");
        repeat ($urandom_range(30, 40)) push_term("0");
        push_term("m");
      end
      14: push_item(atte_pkg::MODE_CLEAR, 8'($urandom), $urandom, $urandom);
      default: begin
        // broken introducer: ESC followed by a random byte, mostly other than '['
        push_term(atte_pkg::CH_ESC);
        push_term(8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (item_q.size() != 0 || in_tvalid || cmd_q.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(atte_pkg::reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    case (idx)
      atte_pkg::REG_COLUMNS:    scr_cols = val & 32'h3ff;
      atte_pkg::REG_TEXT_ROWS:  scr_rows = val & 32'h1ff;
      atte_pkg::REG_DEFAULT_FG: dflt_fg = val;
      default:                  dflt_bg = val;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  int cols_set[7] = '{1, 512, 0, 1023, 20, 80, 9};
  int rows_set[7] = '{1, 256, 0, 511, 6, 24, 3};

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part under the reset screen size
    push_term("A");
    push_term(8'h7e);
    push_term(atte_pkg::CH_TAB);
    push_term(atte_pkg::CH_BS);
    push_term(atte_pkg::CH_CR);
    push_term(atte_pkg::CH_LF);
    push_term(8'h01);
    push_term(8'h7f);
    push_item(atte_pkg::MODE_RAW, 8'h00, '0, '0);
    push_item(atte_pkg::MODE_RAW, 8'hff, '1, '1);
    push_item(atte_pkg::MODE_COLOR, 8'h00, 32'hffff_ffff, 32'h0000_0000);
    push_seq(1, 1, atte_pkg::PRIV_CURSOR, 0, "h");
    push_term("x");
    push_seq(0, 2, 48, 200, "H");
    push_term(atte_pkg::CH_LF);
    push_seq(0, 0, 0, 0, "K");
    push_seq(0, 2, 31, 47, "m");
    push_seq(0, 1, 2, 0, "J");
    push_item(atte_pkg::MODE_CLEAR, 8'hff, '1, '1);
    wait_idle();

    for (int p = 0; p < 7; p++) begin
      write_reg(atte_pkg::REG_COLUMNS, 32'(cols_set[p]));
      write_reg(atte_pkg::REG_TEXT_ROWS, 32'(rows_set[p]));
      write_reg(atte_pkg::REG_DEFAULT_FG,
                p == 0 ? 32'hffff_ffff : (p == 2 ? 32'h0 : $urandom));
      write_reg(atte_pkg::REG_DEFAULT_BG,
                p == 0 ? 32'h0 : (p == 2 ? 32'hffff_ffff : $urandom));
      no_idle = (p == 4);
      if (p == 5) hold_go = 1;
      while (n_pushed < 19 + (p + 1) * 70) push_random_chunk();
      wait_idle();
    end

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
